@@ rtl/gmd_pkg.sv @@
// Shared constants, types and helper functions for the grid maze carver.
package gmd_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W      = COORD_W + 1;
  localparam int CELL_W      = 2 * COORD_W;
  localparam int STACK_DEPTH = 4096;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = STK_AW + 1;

  localparam logic [SIDE_W-1:0]  GRID_W_RST  = SIDE_W'(16);
  localparam logic [SIDE_W-1:0]  GRID_H_RST  = SIDE_W'(16);
  localparam logic [COORD_W-1:0] START_X_RST = '0;
  localparam logic [COORD_W-1:0] START_Y_RST = '0;

  // register indexes on the APB port (byte address = 4 * index)
  localparam logic [1:0] REG_GRID_W  = 2'd0;
  localparam logic [1:0] REG_GRID_H  = 2'd1;
  localparam logic [1:0] REG_START_X = 2'd2;
  localparam logic [1:0] REG_START_Y = 2'd3;

  // wall / neighbor directions, also bit positions in candidate masks
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic KIND_STEP    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic [SIDE_W-1:0]  grid_width;
    logic [SIDE_W-1:0]  grid_height;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
  } cfg_t;

  typedef struct packed {
    logic restart;    // restart item accepted
    logic hold;       // step item accepted with empty stack
    logic rd_cur;     // step item accepted, fetch current row
    logic cap_cur;    // capture current row, fetch north row
    logic cap_north;  // capture north bit, fetch south row
    logic decide;     // use south bit, choose, push or start pop
    logic pop_load;   // load popped cell
    logic out_load;   // move result into output register
  } cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic no_cand;
  } stat_t;

  function automatic logic [2:0] count4(input logic [3:0] m);
    count4 = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
  endfunction

  // pick mod n for n in 1..4; base-4 digit sum works since 4 == 1 mod 3
  function automatic logic [1:0] pick_mod(input logic [7:0] p, input logic [2:0] n);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    unique case (n)
      3'd2:    pick_mod = {1'b0, p[0]};
      3'd3:    pick_mod = t[1:0];
      3'd4:    pick_mod = p[1:0];
      default: pick_mod = 2'd0;
    endcase
  endfunction

  // position of the k-th set bit of m, counted from bit 0
  function automatic logic [1:0] kth_dir(input logic [3:0] m, input logic [1:0] k);
    logic [2:0] seen;
    kth_dir = DIR_N;
    seen    = '0;
    for (int d = 0; d < 4; d++) begin
      if (m[d]) begin
        if (seen == 3'(k)) kth_dir = 2'(d);
        seen = seen + 3'd1;
      end
    end
  endfunction

endpackage

@@ rtl/grid_maze_dfs_carver.sv @@
// Top level of the depth-first grid maze carver: APB registers, sequencer and datapath.
//
// Each input transfer advances a recursive-backtracker maze walk by one step (kind 0) or
// restarts it from the start cell (kind 1), and yields exactly one result transfer. A step
// marks the current cell visited, looks at the north, east, south and west neighbors that are
// inside the grid and unvisited, and either carves toward neighbor (random_pick mod count),
// pushing it on the cell stack, or pops the stack to backtrack. The visited map is a
// 64 x 64-bit row memory with one read/write port plus a per-row valid flop, so a restart
// clears it by clearing the valid flops; the cell stack is a 4096 x 12-bit one-port memory
// whose bottom entry gets the start cell during reset. After an item is accepted, a carving
// step reads the current, north and south rows in turn on the visited port, then makes the
// decision with row write-back and stack push; a backtracking step adds a pop state that
// loads the popped cell; a restart or a step with an empty stack goes straight to the output
// state, which loads the output register unless a result there is still stalled. in_stall is
// high from the accepting edge until the result is loaded, so a new input transfer is taken
// only after the last item is through. The output register holds its result while the next
// input transfer is taken. Registers: grid_width at 0x0, grid_height at 0x4, start_x at 0x8,
// start_y at 0xC; write them only while no item is in flight.
module grid_maze_dfs_carver (
  input  logic                        clk,
  input  logic                        rst_n,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [7:0]                  in_random_pick,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_carved,
  output logic [gmd_pkg::COORD_W-1:0] out_from_x,
  output logic [gmd_pkg::COORD_W-1:0] out_from_y,
  output logic [1:0]                  out_wall_dir,
  output logic [gmd_pkg::COORD_W-1:0] out_cur_x,
  output logic [gmd_pkg::COORD_W-1:0] out_cur_y,
  output logic                        out_done_res
);
  import gmd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  cmd_t       cmd;
  stat_t      stat;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  // config write completes on the access phase; no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRID_W:  cfg_nxt.grid_width  = pwdata[SIDE_W-1:0];
        REG_GRID_H:  cfg_nxt.grid_height = pwdata[SIDE_W-1:0];
        REG_START_X: cfg_nxt.start_x     = pwdata[COORD_W-1:0];
        REG_START_Y: cfg_nxt.start_y     = pwdata[COORD_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width  <= GRID_W_RST;
      cfg_r.grid_height <= GRID_H_RST;
      cfg_r.start_x     <= START_X_RST;
      cfg_r.start_y     <= START_Y_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_GRID_W:  prdata = 32'(cfg_r.grid_width);
      REG_GRID_H:  prdata = 32'(cfg_r.grid_height);
      REG_START_X: prdata = 32'(cfg_r.start_x);
      REG_START_Y: prdata = 32'(cfg_r.start_y);
      default:     prdata = '0;
    endcase
  end

  gmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  gmd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .stat           (stat),
    .in_random_pick (in_random_pick),
    .out_carved     (out_carved),
    .out_from_x     (out_from_x),
    .out_from_y     (out_from_y),
    .out_wall_dir   (out_wall_dir),
    .out_cur_x      (out_cur_x),
    .out_cur_y      (out_cur_y),
    .out_done_res   (out_done_res)
  );

`ifndef ASSERT_OFF
  // an accepted item keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // a finished walk never reports a carve
  a_done_no_carve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_carved))
    else $error("carve reported with empty stack");

  // an east carve moves the current cell one column right
  a_east_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carved && (out_wall_dir == DIR_E) |->
      (out_cur_x == out_from_x + COORD_W'(1)) && (out_cur_y == out_from_y))
    else $error("east carve not adjacent");

  // a south carve moves the current cell one row down
  a_south_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carved && (out_wall_dir == DIR_S) |->
      (out_cur_y == out_from_y + COORD_W'(1)) && (out_cur_x == out_from_x))
    else $error("south carve not adjacent");
`endif

endmodule

@@ rtl/gmd_ctrl.sv @@
// Step sequencer: walks each item through row fetches, decision and result handoff.
module gmd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  input  gmd_pkg::stat_t stat,
  output gmd_pkg::cmd_t  cmd
);
  import gmd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LDC  = 6'b000010,
    S_GTN  = 6'b000100,
    S_GTS  = 6'b001000,
    S_POP  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_RESTART) begin
            cmd.restart = 1'b1;
            state_nxt   = S_OUT;
          end else if (stat.stack_empty) begin
            cmd.hold  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            cmd.rd_cur = 1'b1;
            state_nxt  = S_LDC;
          end
        end
      end
      S_LDC: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = S_GTN;
      end
      S_GTN: begin
        cmd.cap_north = 1'b1;
        state_nxt     = S_GTS;
      end
      S_GTS: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.no_cand ? S_POP : S_OUT;
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/gmd_dpath.sv @@
// Datapath: visited row memory, cell stack, current cell, neighbor choice, result register.
module gmd_dpath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gmd_pkg::cfg_t           cfg,
  input  gmd_pkg::cmd_t           cmd,
  output gmd_pkg::stat_t          stat,
  input  logic [7:0]              in_random_pick,
  output logic                    out_carved,
  output logic [gmd_pkg::COORD_W-1:0] out_from_x,
  output logic [gmd_pkg::COORD_W-1:0] out_from_y,
  output logic [1:0]              out_wall_dir,
  output logic [gmd_pkg::COORD_W-1:0] out_cur_x,
  output logic [gmd_pkg::COORD_W-1:0] out_cur_y,
  output logic                    out_done_res
);
  import gmd_pkg::*;

  // visited map: one row of MAX_SIDE bits per word, per-row valid flops
  logic [MAX_SIDE-1:0] vis_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] vis_rdata_r;
  logic                vis_rvld_r;
  logic [COORD_W-1:0]  vis_addr;
  logic                vis_we;
  logic [MAX_SIDE-1:0] row_q;

  logic [CELL_W-1:0]   stk_mem [STACK_DEPTH];
  logic [CELL_W-1:0]   stk_rdata_r;
  logic [STK_AW-1:0]   stk_addr;
  logic [CELL_W-1:0]   stk_wdata;
  logic                stk_we;

  logic [COORD_W-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_m1;
  logic [MAX_SIDE-1:0] row_vld_r, row_vld_nxt;
  logic [7:0]          pick_r, pick_nxt;
  logic [MAX_SIDE-1:0] cur_row_r, cur_row_nxt;
  logic                nbr_n_r, nbr_n_nxt, nbr_e_r, nbr_e_nxt, nbr_w_r, nbr_w_nxt;
  logic                res_carved_r, res_carved_nxt;
  logic [COORD_W-1:0]  res_fx_r, res_fx_nxt, res_fy_r, res_fy_nxt;
  logic [1:0]          res_dir_r, res_dir_nxt;
  logic                out_carved_r, out_carved_nxt;
  logic [COORD_W-1:0]  out_fx_r, out_fx_nxt, out_fy_r, out_fy_nxt;
  logic [1:0]          out_dir_r, out_dir_nxt;
  logic [COORD_W-1:0]  out_cx_r, out_cx_nxt, out_cy_r, out_cy_nxt;
  logic                out_done_r, out_done_nxt;

  logic [SIDE_W-1:0]   eff_w, eff_h, cx7, cy7;
  logic [COORD_W-1:0]  sx, sy, idx_e, idx_w, step_x, step_y;
  logic [3:0]          inb, vis4, cand;
  logic [2:0]          n_cand;
  logic [1:0]          k_sel, dir_sel;
  logic                no_cand, cnt_full;

  // grid size clamped to 1..MAX_SIDE
  always_comb begin
    eff_w = cfg.grid_width;
    eff_h = cfg.grid_height;
    if (eff_w == '0) eff_w = SIDE_W'(1);
    else if (eff_w > SIDE_W'(MAX_SIDE)) eff_w = SIDE_W'(MAX_SIDE);
    if (eff_h == '0) eff_h = SIDE_W'(1);
    else if (eff_h > SIDE_W'(MAX_SIDE)) eff_h = SIDE_W'(MAX_SIDE);
  end

  assign sx = ({1'b0, cfg.start_x} < eff_w) ? cfg.start_x : COORD_W'(eff_w - SIDE_W'(1));
  assign sy = ({1'b0, cfg.start_y} < eff_h) ? cfg.start_y : COORD_W'(eff_h - SIDE_W'(1));

  assign cx7   = {1'b0, cur_x_r};
  assign cy7   = {1'b0, cur_y_r};
  assign idx_e = cur_x_r + COORD_W'(1);
  assign idx_w = cur_x_r - COORD_W'(1);
  assign row_q = vis_rvld_r ? vis_rdata_r : '0;

  // bounds first; an out-of-bounds neighbor's visited bit is never used
  assign inb[DIR_N] = (cur_y_r != '0) && (cx7 < eff_w) && ((cy7 - SIDE_W'(1)) < eff_h);
  assign inb[DIR_E] = ((cx7 + SIDE_W'(1)) < eff_w) && (cy7 < eff_h);
  assign inb[DIR_S] = ((cy7 + SIDE_W'(1)) < eff_h) && (cx7 < eff_w);
  assign inb[DIR_W] = (cur_x_r != '0) && ((cx7 - SIDE_W'(1)) < eff_w) && (cy7 < eff_h);

  assign vis4[DIR_N] = nbr_n_r;
  assign vis4[DIR_E] = nbr_e_r;
  assign vis4[DIR_S] = row_q[cur_x_r];
  assign vis4[DIR_W] = nbr_w_r;

  assign cand    = inb & ~vis4;
  assign n_cand  = count4(cand);
  assign k_sel   = pick_mod(pick_r, n_cand);
  assign dir_sel = kth_dir(cand, k_sel);
  assign no_cand = (cand == '0);

  always_comb begin
    step_x = cur_x_r;
    step_y = cur_y_r;
    unique case (dir_sel)
      DIR_N: step_y = cur_y_r - COORD_W'(1);
      DIR_E: step_x = cur_x_r + COORD_W'(1);
      DIR_S: step_y = cur_y_r + COORD_W'(1);
      DIR_W: step_x = cur_x_r - COORD_W'(1);
      default: step_x = cur_x_r;
    endcase
  end

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_full = (cnt_r == CNT_W'(STACK_DEPTH));

  assign stat.stack_empty = (cnt_r == '0);
  assign stat.no_cand     = no_cand;

  // visited memory port
  always_comb begin
    priority if (cmd.cap_cur)   vis_addr = cur_y_r - COORD_W'(1);
    else if     (cmd.cap_north) vis_addr = cur_y_r + COORD_W'(1);
    else                        vis_addr = cur_y_r;
  end
  assign vis_we = cmd.decide;

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_addr] <= cur_row_r;
    vis_rdata_r <= vis_mem[vis_addr];
    vis_rvld_r  <= row_vld_r[vis_addr];
  end

  // stack memory port; reset puts the start cell in the bottom entry
  always_comb begin
    priority if (!rst_n) begin
      stk_addr  = '0;
      stk_wdata = {START_Y_RST, START_X_RST};
    end else if (cmd.restart) begin
      stk_addr  = '0;
      stk_wdata = {sy, sx};
    end else if (no_cand) begin
      stk_addr  = cnt_m1[STK_AW-1:0];
      stk_wdata = {step_y, step_x};
    end else begin
      stk_addr  = cnt_r[STK_AW-1:0];
      stk_wdata = {step_y, step_x};
    end
  end
  assign stk_we = ~rst_n | cmd.restart | (cmd.decide & ~no_cand & ~cnt_full);

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_addr] <= stk_wdata;
    stk_rdata_r <= stk_mem[stk_addr];
  end

  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cnt_nxt        = cnt_r;
    row_vld_nxt    = row_vld_r;
    pick_nxt       = pick_r;
    cur_row_nxt    = cur_row_r;
    nbr_n_nxt      = nbr_n_r;
    nbr_e_nxt      = nbr_e_r;
    nbr_w_nxt      = nbr_w_r;
    res_carved_nxt = res_carved_r;
    res_fx_nxt     = res_fx_r;
    res_fy_nxt     = res_fy_r;
    res_dir_nxt    = res_dir_r;
    out_carved_nxt = out_carved_r;
    out_fx_nxt     = out_fx_r;
    out_fy_nxt     = out_fy_r;
    out_dir_nxt    = out_dir_r;
    out_cx_nxt     = out_cx_r;
    out_cy_nxt     = out_cy_r;
    out_done_nxt   = out_done_r;

    if (cmd.restart || cmd.hold) begin
      res_carved_nxt = 1'b0;
      res_fx_nxt     = '0;
      res_fy_nxt     = '0;
      res_dir_nxt    = DIR_N;
    end
    if (cmd.restart) begin
      row_vld_nxt = '0;
      cur_x_nxt   = sx;
      cur_y_nxt   = sy;
      cnt_nxt     = CNT_W'(1);
    end
    if (cmd.rd_cur) pick_nxt = in_random_pick;
    if (cmd.cap_cur) begin
      cur_row_nxt = row_q | (MAX_SIDE'(1) << cur_x_r);
      nbr_e_nxt   = row_q[idx_e];
      nbr_w_nxt   = row_q[idx_w];
    end
    if (cmd.cap_north) nbr_n_nxt = row_q[cur_x_r];
    if (cmd.decide) begin
      row_vld_nxt[cur_y_r] = 1'b1;
      if (no_cand) begin
        cnt_nxt        = cnt_m1;
        res_carved_nxt = 1'b0;
        res_fx_nxt     = '0;
        res_fy_nxt     = '0;
        res_dir_nxt    = DIR_N;
      end else begin
        res_carved_nxt = 1'b1;
        res_fx_nxt     = cur_x_r;
        res_fy_nxt     = cur_y_r;
        res_dir_nxt    = dir_sel;
        cur_x_nxt      = step_x;
        cur_y_nxt      = step_y;
        if (!cnt_full) cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.pop_load) begin
      cur_x_nxt = stk_rdata_r[COORD_W-1:0];
      cur_y_nxt = stk_rdata_r[CELL_W-1:COORD_W];
    end
    if (cmd.out_load) begin
      out_carved_nxt = res_carved_r;
      out_fx_nxt     = res_fx_r;
      out_fy_nxt     = res_fy_r;
      out_dir_nxt    = res_dir_r;
      out_cx_nxt     = cur_x_r;
      out_cy_nxt     = cur_y_r;
      out_done_nxt   = (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= START_X_RST;
      cur_y_r   <= START_Y_RST;
      cnt_r     <= CNT_W'(1);
      row_vld_r <= '0;
    end else begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      cnt_r     <= cnt_nxt;
      row_vld_r <= row_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r       <= pick_nxt;
    cur_row_r    <= cur_row_nxt;
    nbr_n_r      <= nbr_n_nxt;
    nbr_e_r      <= nbr_e_nxt;
    nbr_w_r      <= nbr_w_nxt;
    res_carved_r <= res_carved_nxt;
    res_fx_r     <= res_fx_nxt;
    res_fy_r     <= res_fy_nxt;
    res_dir_r    <= res_dir_nxt;
    out_carved_r <= out_carved_nxt;
    out_fx_r     <= out_fx_nxt;
    out_fy_r     <= out_fy_nxt;
    out_dir_r    <= out_dir_nxt;
    out_cx_r     <= out_cx_nxt;
    out_cy_r     <= out_cy_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_carved   = out_carved_r;
  assign out_from_x   = out_fx_r;
  assign out_from_y   = out_fy_r;
  assign out_wall_dir = out_dir_r;
  assign out_cur_x    = out_cx_r;
  assign out_cur_y    = out_cy_r;
  assign out_done_res = out_done_r;

endmodule
